// ===== hdl/euler_pose_to_transform_assert.svh =====
// assertion macros used by the checker file of the pose transform block
`ifndef EULER_POSE_TO_TRANSFORM_ASSERT_SVH
`define EULER_POSE_TO_TRANSFORM_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define EPT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define EPT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/ept_pkg.sv =====
// shared types, constants and rounding functions of the pose transform block
`timescale 1ns / 1ps

package ept_pkg;

    // field formats
    localparam int ANGLE_W         = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int SHIFT_W         = 32;
    localparam int ROT_W           = 16;
    localparam int ROT_FRAC_BITS   = 14;
    localparam int ROW_W           = 2;

    // internal fixed point, Q30
    localparam int Q_FRAC  = 30;
    localparam int A30_SH  = Q_FRAC - ANGLE_FRAC_BITS;
    localparam int ROT_SH  = Q_FRAC - ROT_FRAC_BITS;
    localparam int RED_W   = 36;
    localparam int TERM_W  = 31;
    localparam int X2_W    = 32;
    localparam int ACC_W   = 34;
    localparam int ENT_W   = 34;
    localparam int RCP_W   = 33;

    localparam logic signed [RED_W-1:0] PI30      = 36'sd3373259426;
    localparam logic signed [RED_W-1:0] TWO_PI30  = 36'sd6746518852;
    localparam logic signed [RED_W-1:0] HALF_PI30 = 36'sd1686629713;

    localparam int ROT_ONE = 1 << ROT_FRAC_BITS;

    // pipeline depths
    localparam int SC_LAT   = 21;
    localparam int MX_LAT   = 5;
    localparam int PIPE_LAT = SC_LAT + MX_LAT;

    // row codes
    localparam logic [ROW_W-1:0] ROW_FIRST = 2'd0;
    localparam logic [ROW_W-1:0] ROW_MID   = 2'd1;
    localparam logic [ROW_W-1:0] ROW_LAST  = 2'd2;

    typedef logic signed [31:0]        t_q30;
    typedef logic signed [63:0]        t_prod;
    typedef logic signed [ENT_W-1:0]   t_ent;
    typedef logic signed [ROT_W-1:0]   t_rot;
    typedef logic signed [SHIFT_W-1:0] t_shift;
    typedef logic signed [ANGLE_W-1:0] t_angle;
    typedef t_rot [0:2]                t_row;
    typedef t_row [0:2]                t_mat;

    localparam t_rot ROT_LIM = t_rot'(ROT_ONE);

    // taylor series: floor division by n(n+1) as multiply by ceil(2^(32+l)/d)
    // then shift by 32+l, with 2^l >= d; exact for dividends below 2^32
    localparam int SIN_TERMS = 7;
    localparam int N_TERMS   = 8;

    localparam logic [RCP_W-1:0] SIN_RCP [1:SIN_TERMS] = '{
        RCP_W'(((64'd1 << 35) + 64'd5)   / 64'd6),
        RCP_W'(((64'd1 << 37) + 64'd19)  / 64'd20),
        RCP_W'(((64'd1 << 38) + 64'd41)  / 64'd42),
        RCP_W'(((64'd1 << 39) + 64'd71)  / 64'd72),
        RCP_W'(((64'd1 << 39) + 64'd109) / 64'd110),
        RCP_W'(((64'd1 << 40) + 64'd155) / 64'd156),
        RCP_W'(((64'd1 << 40) + 64'd209) / 64'd210)
    };
    localparam int SIN_SH [1:SIN_TERMS] = '{35, 37, 38, 39, 39, 40, 40};

    localparam logic [RCP_W-1:0] COS_RCP [1:N_TERMS] = '{
        RCP_W'(((64'd1 << 33) + 64'd1)   / 64'd2),
        RCP_W'(((64'd1 << 36) + 64'd11)  / 64'd12),
        RCP_W'(((64'd1 << 37) + 64'd29)  / 64'd30),
        RCP_W'(((64'd1 << 38) + 64'd55)  / 64'd56),
        RCP_W'(((64'd1 << 39) + 64'd89)  / 64'd90),
        RCP_W'(((64'd1 << 40) + 64'd131) / 64'd132),
        RCP_W'(((64'd1 << 40) + 64'd181) / 64'd182),
        RCP_W'(((64'd1 << 40) + 64'd239) / 64'd240)
    };
    localparam int COS_SH [1:N_TERMS] = '{33, 36, 37, 38, 39, 40, 40, 40};

    // q60 product back to q30, half away from zero
    function automatic t_q30 qround(input t_prod p);
        logic [63:0] mag;
        logic [63:0] rnd;
        mag = p[63] ? 64'(-p) : 64'(p);
        rnd = (mag + (64'd1 << (Q_FRAC - 1))) >> Q_FRAC;
        return p[63] ? t_q30'(-rnd) : t_q30'(rnd);
    endfunction

    // q30 entry to rotation format, half away from zero, saturated
    function automatic t_rot to_rot(input t_ent v);
        logic [ENT_W-1:0] mag;
        logic [ENT_W-1:0] rnd;
        mag = v[ENT_W-1] ? ENT_W'(-v) : ENT_W'(v);
        rnd = (mag + (ENT_W'(1) << (ROT_SH - 1))) >> ROT_SH;
        if (rnd > ENT_W'(ROT_ONE)) begin
            rnd = ENT_W'(ROT_ONE);
        end
        return v[ENT_W-1] ? t_rot'(-rnd) : t_rot'(rnd);
    endfunction

endpackage

// ===== hdl/ept_sincos.sv =====
// pipelined angle reduction and taylor sine / cosine, one angle per cycle while i_en is high
`timescale 1ns / 1ps

module ept_sincos (
    input  logic            i_clk,
    input  logic            i_en,
    input  ept_pkg::t_angle i_angle,
    output ept_pkg::t_q30   o_sin,
    output ept_pkg::t_q30   o_cos
);
    import ept_pkg::*;

    typedef struct packed {
        logic s_neg;
        logic c_neg;
    } t_sc_flag;

    typedef logic signed [ACC_W-1:0] t_acc;

    localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(1) << Q_FRAC;
    localparam t_acc              ACC_ONE  = t_acc'(1) << Q_FRAC;

    function automatic t_acc clamp_unit(input t_acc v);
        t_acc c;
        if (v < 0) begin
            c = '0;
        end else if (v > ACC_ONE) begin
            c = ACC_ONE;
        end else begin
            c = v;
        end
        return c;
    endfunction

    // stage 1: wrap into [-pi, pi]
    logic signed [RED_W-1:0] a30, n_red, r_red;

    always_comb begin
        a30   = RED_W'(i_angle) <<< A30_SH;
        n_red = a30;
        if (a30 > PI30) begin
            n_red = a30 - TWO_PI30;
        end else if (a30 < -PI30) begin
            n_red = a30 + TWO_PI30;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_red <= n_red;
        end
    end

    // stage 2: magnitude, fold into first quadrant
    logic signed [RED_W-1:0] mag;
    logic [TERM_W-1:0]       n_m, r_m;
    t_sc_flag                n_f2, r_f2;

    always_comb begin
        mag        = r_red[RED_W-1] ? -r_red : r_red;
        n_f2.s_neg = r_red[RED_W-1];
        if (mag > HALF_PI30) begin
            n_m        = TERM_W'(PI30 - mag);
            n_f2.c_neg = 1'b1;
        end else begin
            n_m        = TERM_W'(mag);
            n_f2.c_neg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m  <= n_m;
            r_f2 <= n_f2;
        end
    end

    // stage 3 onward: square, then two stages per series term
    logic [TERM_W-1:0] r_ts  [0:SIN_TERMS];
    logic [TERM_W-1:0] r_tc  [0:N_TERMS];
    logic [X2_W-1:0]   r_ps  [1:SIN_TERMS];
    logic [X2_W-1:0]   r_pc  [1:N_TERMS];
    logic [X2_W-1:0]   r_xb  [0:N_TERMS-1];
    logic [X2_W-1:0]   r_xa  [1:N_TERMS-1];
    t_acc              r_ssb [0:N_TERMS];
    t_acc              r_csb [0:N_TERMS];
    t_acc              r_ssa [1:N_TERMS];
    t_acc              r_csa [1:N_TERMS];
    t_sc_flag          r_fb  [0:N_TERMS];
    t_sc_flag          r_fa  [1:N_TERMS];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xb[0]  <= X2_W'((64'(r_m) * 64'(r_m)) >> Q_FRAC);
            r_ts[0]  <= r_m;
            r_tc[0]  <= TERM_ONE;
            r_ssb[0] <= t_acc'(r_m);
            r_csb[0] <= ACC_ONE;
            r_fb[0]  <= r_f2;
        end
    end

    for (genvar k = 1; k <= N_TERMS; k++) begin : g_term
        // for k above 1 the term that joins the sums here has index k-1; odd index subtracts
        localparam bit SUB_PREV = ((k - 1) % 2) == 1;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_pc[k] <= X2_W'((64'(r_tc[k-1]) * 64'(r_xb[k-1])) >> Q_FRAC);
                r_fa[k] <= r_fb[k-1];
                r_tc[k] <= TERM_W'((65'(r_pc[k]) * 65'(COS_RCP[k])) >> COS_SH[k]);
                r_fb[k] <= r_fa[k];
                r_ssb[k] <= r_ssa[k];
                r_csb[k] <= r_csa[k];
            end
        end

        if (k == 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ssa[k] <= r_ssb[k-1];
                    r_csa[k] <= r_csb[k-1];
                end
            end
        end else if (SUB_PREV) begin : g_sub
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ssa[k] <= r_ssb[k-1] - t_acc'(r_ts[k-1]);
                    r_csa[k] <= r_csb[k-1] - t_acc'(r_tc[k-1]);
                end
            end
        end else begin : g_add
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ssa[k] <= r_ssb[k-1] + t_acc'(r_ts[k-1]);
                    r_csa[k] <= r_csb[k-1] + t_acc'(r_tc[k-1]);
                end
            end
        end

        if (k <= SIN_TERMS) begin : g_sin
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_ps[k] <= X2_W'((64'(r_ts[k-1]) * 64'(r_xb[k-1])) >> Q_FRAC);
                    r_ts[k] <= TERM_W'((65'(r_ps[k]) * 65'(SIN_RCP[k])) >> SIN_SH[k]);
                end
            end
        end

        if (k < N_TERMS) begin : g_x2
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_xa[k] <= r_xb[k-1];
                    r_xb[k] <= r_xa[k];
                end
            end
        end
    end

    // last cosine term has even index and adds
    t_acc     r_sf, r_cf;
    t_sc_flag r_ff;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sf <= r_ssb[N_TERMS];
            r_cf <= r_csb[N_TERMS] + t_acc'(r_tc[N_TERMS]);
            r_ff <= r_fb[N_TERMS];
        end
    end

    // clamp to [0, 1] and apply quadrant signs
    t_acc s_cl, c_cl;
    t_q30 r_sin, r_cos;

    always_comb begin
        s_cl = clamp_unit(r_sf);
        c_cl = clamp_unit(r_cf);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_ff.s_neg ? t_q30'(-s_cl) : t_q30'(s_cl);
            r_cos <= r_ff.c_neg ? t_q30'(-c_cl) : t_q30'(c_cl);
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

// ===== hdl/ept_matrix.sv =====
// pipelined rz*ry*rx rotation matrix from sines and cosines
`timescale 1ns / 1ps

module ept_matrix (
    input  logic          i_clk,
    input  logic          i_en,
    input  ept_pkg::t_q30 i_sx,
    input  ept_pkg::t_q30 i_cx,
    input  ept_pkg::t_q30 i_sy,
    input  ept_pkg::t_q30 i_cy,
    input  ept_pkg::t_q30 i_sz,
    input  ept_pkg::t_q30 i_cz,
    output ept_pkg::t_mat o_mat
);
    import ept_pkg::*;

    // stage 1: first products
    t_prod r1_czsy, r1_szsy, r1_00, r1_szcx, r1_szsx, r1_10, r1_czcx, r1_czsx, r1_21, r1_22;
    t_q30  r1_sx, r1_cx, r1_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_czsy <= t_prod'(i_cz) * t_prod'(i_sy);
            r1_szsy <= t_prod'(i_sz) * t_prod'(i_sy);
            r1_00   <= t_prod'(i_cz) * t_prod'(i_cy);
            r1_szcx <= t_prod'(i_sz) * t_prod'(i_cx);
            r1_szsx <= t_prod'(i_sz) * t_prod'(i_sx);
            r1_10   <= t_prod'(i_sz) * t_prod'(i_cy);
            r1_czcx <= t_prod'(i_cz) * t_prod'(i_cx);
            r1_czsx <= t_prod'(i_cz) * t_prod'(i_sx);
            r1_21   <= t_prod'(i_cy) * t_prod'(i_sx);
            r1_22   <= t_prod'(i_cy) * t_prod'(i_cx);
            r1_sx   <= i_sx;
            r1_cx   <= i_cx;
            r1_sy   <= i_sy;
        end
    end

    // stage 2: round to q30
    t_q30 r2_czsy, r2_szsy, r2_00, r2_szcx, r2_szsx, r2_10, r2_czcx, r2_czsx, r2_21, r2_22;
    t_q30 r2_sx, r2_cx, r2_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_czsy <= qround(r1_czsy);
            r2_szsy <= qround(r1_szsy);
            r2_00   <= qround(r1_00);
            r2_szcx <= qround(r1_szcx);
            r2_szsx <= qround(r1_szsx);
            r2_10   <= qround(r1_10);
            r2_czcx <= qround(r1_czcx);
            r2_czsx <= qround(r1_czsx);
            r2_21   <= qround(r1_21);
            r2_22   <= qround(r1_22);
            r2_sx   <= r1_sx;
            r2_cx   <= r1_cx;
            r2_sy   <= r1_sy;
        end
    end

    // stage 3: triple products
    t_prod r3_pa, r3_pb, r3_pc, r3_pd;
    t_q30  r3_00, r3_szcx, r3_szsx, r3_10, r3_czcx, r3_czsx, r3_21, r3_22, r3_sy;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_pa   <= t_prod'(r2_czsy) * t_prod'(r2_sx);
            r3_pb   <= t_prod'(r2_czsy) * t_prod'(r2_cx);
            r3_pc   <= t_prod'(r2_szsy) * t_prod'(r2_sx);
            r3_pd   <= t_prod'(r2_szsy) * t_prod'(r2_cx);
            r3_00   <= r2_00;
            r3_szcx <= r2_szcx;
            r3_szsx <= r2_szsx;
            r3_10   <= r2_10;
            r3_czcx <= r2_czcx;
            r3_czsx <= r2_czsx;
            r3_21   <= r2_21;
            r3_22   <= r2_22;
            r3_sy   <= r2_sy;
        end
    end

    // stage 4: round and combine
    t_ent r4 [0:2][0:2];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4[0][0] <= t_ent'(r3_00);
            r4[0][1] <= t_ent'(qround(r3_pa)) - t_ent'(r3_szcx);
            r4[0][2] <= t_ent'(qround(r3_pb)) + t_ent'(r3_szsx);
            r4[1][0] <= t_ent'(r3_10);
            r4[1][1] <= t_ent'(qround(r3_pc)) + t_ent'(r3_czcx);
            r4[1][2] <= t_ent'(qround(r3_pd)) - t_ent'(r3_czsx);
            r4[2][0] <= -t_ent'(r3_sy);
            r4[2][1] <= t_ent'(r3_21);
            r4[2][2] <= t_ent'(r3_22);
        end
    end

    // stage 5: output format
    t_mat r5;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r5[i][j] <= to_rot(r4[i][j]);
                end
            end
        end
    end

    assign o_mat = r5;

endmodule

// ===== hdl/euler_pose_to_transform.sv =====
// euler pose to homogeneous transform: top level, pipeline control and row output
// the first row shows on o_valid after the pipeline stages and the output register
// throughput: one request per cycle enters the 26-stage pipeline unless stalled;
//   the single output port sends three rows per request; the next waits on the last row
// reset: synchronous active-low, clears valid bits and the row counter, not the data
`timescale 1ns / 1ps

module euler_pose_to_transform (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_side,
    input  ept_pkg::t_angle   i_angle_x,
    input  ept_pkg::t_angle   i_angle_y,
    input  ept_pkg::t_angle   i_angle_z,
    input  ept_pkg::t_shift   i_shift_x,
    input  ept_pkg::t_shift   i_shift_y,
    input  ept_pkg::t_shift   i_shift_z,
    // row channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_pose_side,
    output logic [ept_pkg::ROW_W-1:0] o_row,
    output ept_pkg::t_rot     o_elem_first,
    output ept_pkg::t_rot     o_elem_second,
    output ept_pkg::t_rot     o_elem_third,
    output ept_pkg::t_shift   o_offset,
    output logic              o_last_row
);
    import ept_pkg::*;

    // side tag and translation ride alongside the math pipeline
    typedef struct packed {
        logic   side;
        t_shift sx;
        t_shift sy;
        t_shift sz;
    } t_pose_tag;

    logic       adv;        // whole pipeline moves this cycle
    logic       out_free;   // output register is free to take a new request this cycle
    logic       pipe_v;     // request waiting at the pipeline end

    logic       r_dv [PIPE_LAT];
    t_pose_tag  r_dp [PIPE_LAT];

    // valid bits, one per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_LAT; i++) begin
                r_dv[i] <= 1'b0;
            end
        end else if (adv) begin
            r_dv[0] <= i_valid;
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_dv[i] <= r_dv[i-1];
            end
        end
    end

    // tag and translation delay line
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dp[0] <= '{side: i_side, sx: i_shift_x, sy: i_shift_y, sz: i_shift_z};
            for (int i = 1; i < PIPE_LAT; i++) begin
                r_dp[i] <= r_dp[i-1];
            end
        end
    end

    // sine and cosine of each angle, SC_LAT stages
    t_q30 sx, cx, sy, cy, sz, cz;

    ept_sincos u_sc_x (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_angle_x),
        .o_sin   (sx),
        .o_cos   (cx)
    );

    ept_sincos u_sc_y (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_angle_y),
        .o_sin   (sy),
        .o_cos   (cy)
    );

    ept_sincos u_sc_z (
        .i_clk   (i_clk),
        .i_en    (adv),
        .i_angle (i_angle_z),
        .o_sin   (sz),
        .o_cos   (cz)
    );

    // rotation matrix, MX_LAT stages, lines up with the last valid bit
    t_mat mx_mat;

    ept_matrix u_mx (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_sx  (sx),
        .i_cx  (cx),
        .i_sy  (sy),
        .i_cy  (cy),
        .i_sz  (sz),
        .i_cz  (cz),
        .o_mat (mx_mat)
    );

    // output register holds one finished request and walks its three rows;
    // it frees up as the last row is taken, so the pipeline keeps moving then
    logic              r_ov;
    logic [ROW_W-1:0]  r_row;
    t_mat              r_mat;
    logic              r_side;
    t_shift            r_off_x, r_off_y, r_off_z;

    assign pipe_v   = r_dv[PIPE_LAT-1];
    assign out_free = !r_ov || (!i_stall && (r_row == ROW_LAST));
    assign adv      = !pipe_v || out_free;
    assign o_stall  = !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= ROW_FIRST;
        end else if (out_free) begin
            r_ov  <= pipe_v;
            r_row <= ROW_FIRST;
        end else if (!i_stall) begin
            r_row <= r_row + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_mat   <= mx_mat;
            r_side  <= r_dp[PIPE_LAT-1].side;
            r_off_x <= r_dp[PIPE_LAT-1].sx;
            r_off_y <= r_dp[PIPE_LAT-1].sy;
            r_off_z <= r_dp[PIPE_LAT-1].sz;
        end
    end

    // row select
    always_comb begin
        unique case (r_row)
            ROW_FIRST: begin
                o_elem_first  = r_mat[0][0];
                o_elem_second = r_mat[0][1];
                o_elem_third  = r_mat[0][2];
                o_offset      = r_off_x;
            end
            ROW_MID: begin
                o_elem_first  = r_mat[1][0];
                o_elem_second = r_mat[1][1];
                o_elem_third  = r_mat[1][2];
                o_offset      = r_off_y;
            end
            default: begin
                o_elem_first  = r_mat[2][0];
                o_elem_second = r_mat[2][1];
                o_elem_third  = r_mat[2][2];
                o_offset      = r_off_z;
            end
        endcase
    end

    assign o_valid     = r_ov;
    assign o_pose_side = r_side;
    assign o_row       = r_row;
    assign o_last_row  = (r_row == ROW_LAST);

endmodule

// ===== hdl/ept_checker.sv =====
// port-level assertions for the pose transform block, with its bind
`timescale 1ns / 1ps

`include "euler_pose_to_transform_assert.svh"

module ept_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic                      o_pose_side,
    input logic [ept_pkg::ROW_W-1:0] o_row,
    input ept_pkg::t_rot             o_elem_first,
    input logic                      o_last_row
);
    import ept_pkg::*;

    // a stalled row holds
    `EPT_ASSERT_NXT(a_stall_hold, o_valid && i_stall, o_valid && $stable(o_row) && $stable(o_elem_first), "stalled row changed")

    // rows of one request follow each other with the same side tag
    `EPT_ASSERT_NXT(a_row_step, o_valid && !i_stall && (o_row != ROW_LAST), o_valid && (o_row == $past(o_row) + 2'd1) && $stable(o_pose_side), "row sequence broken")

    // last mark only on the third row
    `EPT_ASSERT_IMP(a_last_mark, o_valid, o_last_row == (o_row == ROW_LAST), "last row mark wrong")

    // the first rotation entry of each row stays within unit magnitude
    `EPT_ASSERT_IMP(a_elem_range, o_valid, (o_elem_first >= -ROT_LIM) && (o_elem_first <= ROT_LIM), "rotation entry out of range")

endmodule

bind euler_pose_to_transform ept_checker u_ept_checker (.*);
